@@ sv/assert_macros.svh @@
// Assertion macros shared by the extractor RTL.
// No dependencies; ASSERT_OFF compiles every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define LMI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LMI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LMI_ASSERT(lbl, clk, rst, prop, msg)
`define LMI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ sv/lmi_pkg.sv @@
// Shared types, constants and marker tables of the link marker id extractor.
// No dependencies.
`timescale 1ns / 1ps
package lmi_pkg;

  localparam int PLAYER_SLOTS_DEF = 16;
  localparam int TEAM_SLOTS_DEF   = 8;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [31:0] ACC_LIMIT  = 32'd429496729;
  localparam logic [3:0]  PLAYER_LEN = 4'd8;
  localparam logic [3:0]  TEAM_LEN   = 4'd6;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_T     = 8'h74;

  typedef enum logic {KIND_PLAYER = 1'b0, KIND_TEAM = 1'b1} kind_t;

  typedef struct packed {
    logic        clr;
    logic        try_add;
    kind_t       kind;
    logic [31:0] id;
  } cmd_t;

  function automatic logic [7:0] player_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h3A;
      4'd1:    ch = 8'h70;
      4'd2:    ch = 8'h6C;
      4'd3:    ch = 8'h61;
      4'd4:    ch = 8'h79;
      4'd5:    ch = 8'h65;
      4'd6:    ch = 8'h72;
      4'd7:    ch = 8'h23;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] team_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h3A;
      4'd1:    ch = 8'h74;
      4'd2:    ch = 8'h65;
      4'd3:    ch = 8'h61;
      4'd4:    ch = 8'h6D;
      4'd5:    ch = 8'h23;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ sv/lmi_front.sv @@
// Front end: marker matcher and decimal id parser, one byte per request.
// Emits one list command per request. Depends on lmi_pkg.
`timescale 1ns / 1ps
module lmi_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        char_code,
  input  logic              char_present,
  input  logic              clear_lists,
  input  logic              end_of_text,
  output lmi_pkg::cmd_t     cmd
);

  logic [3:0]  mp, mp_next;
  logic        mk, mk_next;
  logic        dm, dm_next;
  logic        ds, ds_next;
  logic        ov, ov_next;
  logic [31:0] acc, acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mp  <= '0;
      mk  <= 1'b0;
      dm  <= 1'b0;
      ds  <= 1'b0;
      ov  <= 1'b0;
      acc <= '0;
    end else if (accept) begin
      mp  <= mp_next;
      mk  <= mk_next;
      dm  <= dm_next;
      ds  <= ds_next;
      ov  <= ov_next;
      acc <= acc_next;
    end
  end

  always_comb begin
    logic       restart;
    logic       is_digit;
    logic [3:0] digit;
    logic [3:0] len;
    logic [7:0] want;
    mp_next  = mp;
    mk_next  = mk;
    dm_next  = dm;
    ds_next  = ds;
    ov_next  = ov;
    acc_next = acc;
    cmd.clr     = clear_lists;
    cmd.try_add = 1'b0;
    cmd.kind    = lmi_pkg::KIND_PLAYER;
    cmd.id      = '0;
    restart  = (char_code == lmi_pkg::CH_COLON);
    is_digit = (char_code >= lmi_pkg::CH_ZERO) && (char_code <= lmi_pkg::CH_NINE);
    digit    = 4'(char_code - lmi_pkg::CH_ZERO);
    len      = lmi_pkg::PLAYER_LEN;
    want     = '0;

    if (clear_lists) begin
      mp_next = '0; mk_next = 1'b0; dm_next = 1'b0;
      ds_next = 1'b0; ov_next = 1'b0; acc_next = '0;
    end

    if (char_present) begin
      if (dm_next && is_digit) begin
        ds_next = 1'b1;
        if (ov_next || acc_next > lmi_pkg::ACC_LIMIT ||
            (acc_next == lmi_pkg::ACC_LIMIT && digit > 4'd5)) begin
          ov_next = 1'b1;
        end else begin
          acc_next = {acc_next[28:0], 3'b000} + {acc_next[30:0], 1'b0} + 32'(digit);
        end
      end else begin
        if (dm_next) begin
          if (char_code == lmi_pkg::CH_GT && ds_next && !ov_next && acc_next != '0) begin
            cmd.try_add = 1'b1;
            cmd.kind    = lmi_pkg::kind_t'(mk_next);
            cmd.id      = acc_next;
          end
          mp_next = '0; mk_next = 1'b0; dm_next = 1'b0;
          ds_next = 1'b0; ov_next = 1'b0; acc_next = '0;
        end
        // advance the marker match
        len  = mk_next ? lmi_pkg::TEAM_LEN : lmi_pkg::PLAYER_LEN;
        want = mk_next ? lmi_pkg::team_char(mp_next) : lmi_pkg::player_char(mp_next);
        priority if (mp_next == 4'd0) begin
          mp_next = restart ? 4'd1 : 4'd0;
        end else if (mp_next == 4'd1) begin
          priority if (char_code == lmi_pkg::CH_P) begin
            mk_next = 1'b0;
            mp_next = 4'd2;
          end else if (char_code == lmi_pkg::CH_T) begin
            mk_next = 1'b1;
            mp_next = 4'd2;
          end else begin
            mp_next = restart ? 4'd1 : 4'd0;
          end
        end else if (mp_next >= len) begin
          mp_next = restart ? 4'd1 : 4'd0;
        end else if (char_code == want) begin
          if (mp_next + 4'd1 == len) begin
            mp_next  = '0;
            dm_next  = 1'b1;
            ds_next  = 1'b0;
            ov_next  = 1'b0;
            acc_next = '0;
          end else begin
            mp_next = mp_next + 4'd1;
          end
        end else begin
          mp_next = restart ? 4'd1 : 4'd0;
        end
      end
    end

    if (end_of_text) begin
      mp_next = '0; mk_next = 1'b0; dm_next = 1'b0;
      ds_next = 1'b0; ov_next = 1'b0; acc_next = '0;
    end
  end

endmodule

@@ sv/lmi_cmd_queue.sv @@
// Short command queue between front end and list back end.
// Depends on lmi_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lmi_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  lmi_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_valid,
  output lmi_pkg::cmd_t rd_data
);

  localparam int AW = (lmi_pkg::QUEUE_DEPTH > 1) ? $clog2(lmi_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(lmi_pkg::QUEUE_DEPTH + 1);

  lmi_pkg::cmd_t   entries [lmi_pkg::QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign full     = (count == CW'(lmi_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(lmi_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(lmi_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(wr_en) - CW'(rd_en);
    end
  end

  `LMI_ASSERT(a_queue_count, clk, rst, (count <= CW'(lmi_pkg::QUEUE_DEPTH)), "queue count exceeds depth")

endmodule

@@ sv/lmi_back.sv @@
// Back end: player and team lists, duplicate check, result register.
// Depends on lmi_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lmi_back #(
  parameter int PLAYER_SLOTS = lmi_pkg::PLAYER_SLOTS_DEF,
  parameter int TEAM_SLOTS   = lmi_pkg::TEAM_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  lmi_pkg::cmd_t cmd,
  output logic          cmd_take,
  output logic          empty,
  input  logic          pop,
  output logic          added,
  output logic          kind,
  output logic [31:0]   id_value,
  output logic [3:0]    slot,
  output logic [4:0]    player_total,
  output logic [3:0]    team_total
);

  localparam int PW  = (PLAYER_SLOTS > 1) ? $clog2(PLAYER_SLOTS) : 1;
  localparam int TW  = (TEAM_SLOTS > 1) ? $clog2(TEAM_SLOTS) : 1;
  localparam int PFW = $clog2(PLAYER_SLOTS + 1);
  localparam int TFW = $clog2(TEAM_SLOTS + 1);

  logic [31:0]    player_list [PLAYER_SLOTS];
  logic [31:0]    team_list   [TEAM_SLOTS];
  logic [PFW-1:0] player_fill, player_fill_next;
  logic [TFW-1:0] team_fill, team_fill_next;

  logic           out_valid;
  logic           res_added;
  logic [31:0]    res_slot;
  logic           p_write, t_write;
  logic [PFW-1:0] p_base;
  logic [TFW-1:0] t_base;
  logic           p_hit, t_hit;
  logic [31:0]    pf_wide, tf_wide;

  assign cmd_take = cmd_valid && (!out_valid || pop);
  assign empty    = !out_valid;

  always_comb begin
    p_base = cmd.clr ? '0 : player_fill;
    t_base = cmd.clr ? '0 : team_fill;
    p_hit  = 1'b0;
    t_hit  = 1'b0;
    for (int i = 0; i < PLAYER_SLOTS; i++) begin
      if (PFW'(i) < p_base && player_list[i] == cmd.id) p_hit = 1'b1;
    end
    for (int i = 0; i < TEAM_SLOTS; i++) begin
      if (TFW'(i) < t_base && team_list[i] == cmd.id) t_hit = 1'b1;
    end
    p_write = cmd.try_add && cmd.kind == lmi_pkg::KIND_PLAYER &&
              p_base < PFW'(PLAYER_SLOTS) && !p_hit;
    t_write = cmd.try_add && cmd.kind == lmi_pkg::KIND_TEAM &&
              t_base < TFW'(TEAM_SLOTS) && !t_hit;
    player_fill_next = p_base + PFW'(p_write);
    team_fill_next   = t_base + TFW'(t_write);
    res_added = p_write || t_write;
    res_slot  = p_write ? 32'(p_base) : (t_write ? 32'(t_base) : '0);
  end

  always_ff @(posedge clk) begin
    if (cmd_take && p_write) player_list[p_base[PW-1:0]] <= cmd.id;
    if (cmd_take && t_write) team_list[t_base[TW-1:0]]   <= cmd.id;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      player_fill <= '0;
      team_fill   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd_take) begin
        player_fill <= player_fill_next;
        team_fill   <= team_fill_next;
        out_valid   <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign pf_wide = 32'(player_fill_next);
  assign tf_wide = 32'(team_fill_next);

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      added        <= res_added;
      kind         <= res_added ? cmd.kind : 1'b0;
      id_value     <= res_added ? cmd.id : '0;
      slot         <= res_slot[3:0];
      player_total <= pf_wide[4:0];
      team_total   <= tf_wide[3:0];
    end
  end

  `LMI_ASSERT(a_player_fill_cap, clk, rst, (player_fill <= PFW'(PLAYER_SLOTS)), "player list overfilled")
  `LMI_ASSERT(a_team_fill_cap, clk, rst, (team_fill <= TFW'(TEAM_SLOTS)), "team list overfilled")
  `LMI_ASSERT(a_added_nonzero, clk, rst, (out_valid && added |-> id_value != '0), "zero id added")
  `LMI_ASSERT(a_one_list_write, clk, rst, (cmd_valid |-> !(p_write && t_write)), "both lists written")

endmodule

@@ sv/link_marker_id_extractor.sv @@
// Link marker id extractor: takes one text byte (or a flag-only item) per
// request and returns one result per request. A new request is taken every
// cycle while full is low; a result reaches the result ports by way of a
// two-entry command queue that sits between the marker parser and the list
// stage, and then the list stage's result register. A result held on the ports
// stops the list stage, so the queue fills and full rises after two further
// requests. The duplicate check compares all held ids at once, so the list
// stage also finishes one request per cycle while its result register is free
// or being popped. Lists hold PLAYER_SLOTS and TEAM_SLOTS ids.
`timescale 1ns / 1ps
module link_marker_id_extractor #(
  parameter int PLAYER_SLOTS = lmi_pkg::PLAYER_SLOTS_DEF,
  parameter int TEAM_SLOTS   = lmi_pkg::TEAM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_code,
  input  logic        char_present,
  input  logic        clear_lists,
  input  logic        end_of_text,
  output logic        empty,
  input  logic        pop,
  output logic        added,
  output logic        kind,
  output logic [31:0] id_value,
  output logic [3:0]  slot,
  output logic [4:0]  player_total,
  output logic [3:0]  team_total
);

  logic          accept;
  lmi_pkg::cmd_t front_cmd;
  lmi_pkg::cmd_t queue_cmd;
  logic          queue_valid;
  logic          queue_take;

  assign accept = push && !full;

  lmi_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_code    (char_code),
    .char_present (char_present),
    .clear_lists  (clear_lists),
    .end_of_text  (end_of_text),
    .cmd          (front_cmd)
  );

  lmi_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .wr_data  (front_cmd),
    .full     (full),
    .rd_en    (queue_take),
    .rd_valid (queue_valid),
    .rd_data  (queue_cmd)
  );

  lmi_back #(
    .PLAYER_SLOTS (PLAYER_SLOTS),
    .TEAM_SLOTS   (TEAM_SLOTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (queue_valid),
    .cmd          (queue_cmd),
    .cmd_take     (queue_take),
    .empty        (empty),
    .pop          (pop),
    .added        (added),
    .kind         (kind),
    .id_value     (id_value),
    .slot         (slot),
    .player_total (player_total),
    .team_total   (team_total)
  );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for link_marker_id_extractor: a directed table, then
// random marker text; results checked against table rows or a behavioral model.
// Depends on lmi_pkg and the extractor RTL.
`timescale 1ns / 1ps
module tb_top;

  localparam int TEXT_CHARS     = 64;
  localparam int TOTAL_ITEMS    = 1800;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_AT    = 600;
  localparam int HOLD_OFF_LEN   = 80;
  localparam int DIR_ROWS       = 21;

  localparam logic [63:0] PLAYER_TAG = ":player#";
  localparam logic [47:0] TEAM_TAG   = ":team#";

  typedef struct packed {
    logic            added;
    lmi_pkg::kind_t  kind;
    logic [31:0]     id_value;
    logic [3:0]      slot;
    logic [4:0]      player_total;
    logic [3:0]      team_total;
  } result_t;

  // text empty: one lone item carrying code and pres
  typedef struct packed {
    logic [8*TEXT_CHARS-1:0] text;
    logic [7:0]              code;
    logic                    pres;
    logic                    clr;
    logic                    eot;
    logic                    chk;
    result_t                 want;
  } dir_row_t;

  localparam result_t NO_RESULT = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  char_code = 8'h00;
  logic        char_present = 1'b0;
  logic        clear_lists = 1'b0;
  logic        end_of_text = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        added;
  logic        kind;
  logic [31:0] id_value;
  logic [3:0]  slot;
  logic [4:0]  player_total;
  logic [3:0]  team_total;

  result_t    expected_results[$];
  logic [7:0] seg_bytes[$];
  int         mismatches = 0;
  int         requests_taken = 0;
  int         results_taken = 0;
  int         stall_cycles = 0;

  // model state
  int             tag_pos = 0;
  lmi_pkg::kind_t tag_kind = lmi_pkg::KIND_PLAYER;
  logic           in_digits = 1'b0;
  logic           got_digit = 1'b0;
  logic           id_overflow = 1'b0;
  logic [31:0]    id_acc = '0;
  logic [31:0]    player_store [lmi_pkg::PLAYER_SLOTS_DEF];
  logic [31:0]    team_store [lmi_pkg::TEAM_SLOTS_DEF];
  int             player_held = 0;
  int             team_held = 0;

  logic [7:0] hot_bytes [8] = '{lmi_pkg::CH_COLON, lmi_pkg::CH_GT, 8'h23, lmi_pkg::CH_P,
                                lmi_pkg::CH_T, lmi_pkg::CH_ZERO, lmi_pkg::CH_NINE, 8'h00};

  dir_row_t directed_rows [DIR_ROWS] = '{
    '{"", 8'h00, 1'b1, 1'b0, 1'b0, 1'b1, NO_RESULT},
    '{"", 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1, NO_RESULT},
    '{"", lmi_pkg::CH_COLON, 1'b0, 1'b0, 1'b0, 1'b1, NO_RESULT},
    '{"player#5>", 8'h00, 1'b1, 1'b0, 1'b0, 1'b1, NO_RESULT},
    '{":player#7>", 8'h00, 1'b1, 1'b0, 1'b0, 1'b1,
      '{1'b1, lmi_pkg::KIND_PLAYER, 32'd7, 4'd0, 5'd1, 4'd0}},
    '{":player#7>", 8'h00, 1'b1, 1'b0, 1'b0, 1'b1,
      '{1'b0, lmi_pkg::KIND_PLAYER, 32'd0, 4'd0, 5'd1, 4'd0}},
    '{":team#4294967295>", 8'h00, 1'b1, 1'b0, 1'b0, 1'b1,
      '{1'b1, lmi_pkg::KIND_TEAM, 32'hFFFF_FFFF, 4'd0, 5'd1, 4'd1}},
    '{":team#4294967296>", 8'h00, 1'b1, 1'b0, 1'b0, 1'b1,
      '{1'b0, lmi_pkg::KIND_PLAYER, 32'd0, 4'd0, 5'd1, 4'd1}},
    '{":team#0>", 8'h00, 1'b1, 1'b0, 1'b0, 1'b1,
      '{1'b0, lmi_pkg::KIND_PLAYER, 32'd0, 4'd0, 5'd1, 4'd1}},
    '{":team#>", 8'h00, 1'b1, 1'b0, 1'b0, 1'b1,
      '{1'b0, lmi_pkg::KIND_PLAYER, 32'd0, 4'd0, 5'd1, 4'd1}},
    '{":team#12x>", 8'h00, 1'b1, 1'b0, 1'b0, 1'b1,
      '{1'b0, lmi_pkg::KIND_PLAYER, 32'd0, 4'd0, 5'd1, 4'd1}},
    '{":pla:player#9>", 8'h00, 1'b1, 1'b0, 1'b0, 1'b1,
      '{1'b1, lmi_pkg::KIND_PLAYER, 32'd9, 4'd1, 5'd2, 4'd1}},
    '{":team#34:team#56>", 8'h00, 1'b1, 1'b0, 1'b0, 1'b1,
      '{1'b1, lmi_pkg::KIND_TEAM, 32'd56, 4'd1, 5'd2, 4'd2}},
    '{":player#77", 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{">", 8'h00, 1'b1, 1'b0, 1'b0, 1'b1,
      '{1'b0, lmi_pkg::KIND_PLAYER, 32'd0, 4'd0, 5'd2, 4'd2}},
    '{":team#1>", 8'h00, 1'b1, 1'b1, 1'b0, 1'b1,
      '{1'b1, lmi_pkg::KIND_TEAM, 32'd1, 4'd0, 5'd0, 4'd1}},
    '{":team#2>:team#3>:team#4>:team#5>:team#6>:team#7>:team#8>:team#9>",
      8'h00, 1'b1, 1'b0, 1'b0, 1'b1,
      '{1'b0, lmi_pkg::KIND_PLAYER, 32'd0, 4'd0, 5'd0, 4'd8}},
    '{"", lmi_pkg::CH_T, 1'b0, 1'b1, 1'b1, 1'b1, NO_RESULT},
    '{":player#00042>", 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{":Player#5>:player#1:", 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{":player#4294967295>", 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, NO_RESULT}
  };

  link_marker_id_extractor dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .char_code    (char_code),
    .char_present (char_present),
    .clear_lists  (clear_lists),
    .end_of_text  (end_of_text),
    .empty        (empty),
    .pop          (pop),
    .added        (added),
    .kind         (kind),
    .id_value     (id_value),
    .slot         (slot),
    .player_total (player_total),
    .team_total   (team_total)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void drop_parse();
    tag_pos = 0;
    tag_kind = lmi_pkg::KIND_PLAYER;
    in_digits = 1'b0;
    got_digit = 1'b0;
    id_overflow = 1'b0;
    id_acc = '0;
  endfunction

  function automatic void match_tag(logic [7:0] c);
    int restart;
    int tag_len;
    logic [7:0] want;
    restart = (c == lmi_pkg::CH_COLON) ? 1 : 0;
    tag_len = (tag_kind == lmi_pkg::KIND_TEAM) ? 6 : 8;
    if (tag_pos == 0) begin
      tag_pos = restart;
    end else if (tag_pos == 1) begin
      if (c == lmi_pkg::CH_P) begin
        tag_kind = lmi_pkg::KIND_PLAYER;
        tag_pos = 2;
      end else if (c == lmi_pkg::CH_T) begin
        tag_kind = lmi_pkg::KIND_TEAM;
        tag_pos = 2;
      end else begin
        tag_pos = restart;
      end
    end else if (tag_pos >= tag_len) begin
      tag_pos = restart;
    end else begin
      want = (tag_kind == lmi_pkg::KIND_TEAM) ? TEAM_TAG[8*(5-tag_pos) +: 8]
                                              : PLAYER_TAG[8*(7-tag_pos) +: 8];
      if (c == want) begin
        tag_pos++;
        if (tag_pos == tag_len) begin
          tag_pos = 0;
          in_digits = 1'b1;
          got_digit = 1'b0;
          id_overflow = 1'b0;
          id_acc = '0;
        end
      end else begin
        tag_pos = restart;
      end
    end
  endfunction

  function automatic result_t store_id(lmi_pkg::kind_t k, logic [31:0] id);
    result_t r;
    bit dup;
    r = NO_RESULT;
    dup = 1'b0;
    if (k == lmi_pkg::KIND_TEAM) begin
      for (int i = 0; i < team_held; i++) if (team_store[i] == id) dup = 1'b1;
      if (id != 0 && team_held < lmi_pkg::TEAM_SLOTS_DEF && !dup) begin
        r.added = 1'b1;
        r.kind = lmi_pkg::KIND_TEAM;
        r.id_value = id;
        r.slot = team_held[3:0];
        team_store[team_held] = id;
        team_held++;
      end
    end else begin
      for (int i = 0; i < player_held; i++) if (player_store[i] == id) dup = 1'b1;
      if (id != 0 && player_held < lmi_pkg::PLAYER_SLOTS_DEF && !dup) begin
        r.added = 1'b1;
        r.kind = lmi_pkg::KIND_PLAYER;
        r.id_value = id;
        r.slot = player_held[3:0];
        player_store[player_held] = id;
        player_held++;
      end
    end
    return r;
  endfunction

  function automatic result_t predict_extract(logic [7:0] c, logic pres, logic clr, logic eot);
    result_t r;
    logic [31:0] d;
    r = NO_RESULT;
    if (clr) begin
      drop_parse();
      player_held = 0;
      team_held = 0;
    end
    if (pres) begin
      if (in_digits && c >= lmi_pkg::CH_ZERO && c <= lmi_pkg::CH_NINE) begin
        d = 32'(c - lmi_pkg::CH_ZERO);
        got_digit = 1'b1;
        if (id_overflow || id_acc > lmi_pkg::ACC_LIMIT ||
            (id_acc == lmi_pkg::ACC_LIMIT && d > 5))
          id_overflow = 1'b1;
        else
          id_acc = id_acc * 10 + d;
      end else begin
        if (in_digits) begin
          if (c == lmi_pkg::CH_GT && got_digit && !id_overflow)
            r = store_id(tag_kind, id_acc);
          drop_parse();
        end
        match_tag(c);
      end
    end
    if (eot) drop_parse();
    r.player_total = player_held[4:0];
    r.team_total = team_held[3:0];
    return r;
  endfunction

  task automatic send_req(logic [7:0] c, logic pres, logic clr, logic eot,
                          logic chk, result_t want);
    int gap;
    result_t pred;
    gap = ((requests_taken / 128) % 4 == 3) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    char_code <= c;
    char_present <= pres;
    clear_lists <= clr;
    end_of_text <= eot;
    do @(posedge clk); while (full);
    pred = predict_extract(c, pres, clr, eot);
    expected_results.push_back(chk ? want : pred);
    requests_taken++;
  endtask

  task automatic send_seg(logic clr, logic eot, logic chk, result_t want);
    int last;
    last = seg_bytes.size() - 1;
    for (int n = 0; n <= last; n++)
      send_req(seg_bytes[n], 1'b1, clr && n == 0, eot && n == last, chk && n == last, want);
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) seg_bytes.push_back(s[i]);
  endfunction

  task automatic send_random_seg();
    int r;
    int cut;
    longint unsigned idv;
    logic clr;
    logic eot;
    r = $urandom_range(0, 99);
    clr = ($urandom_range(0, 49) == 0);
    eot = ($urandom_range(0, 19) == 0);
    seg_bytes.delete();
    if (r < 60) begin
      add_text($urandom_range(0, 1) ? ":team#" : ":player#");
      case ($urandom_range(0, 9))
        0: idv = 0;
        1: idv = $urandom();
        2: idv = 64'd4294967290 + $urandom_range(0, 9);
        default: idv = $urandom_range(1, 40);
      endcase
      if ($urandom_range(0, 7) == 0) add_text("0");
      add_text($sformatf("%0d", idv));
      if ($urandom_range(0, 19) < 17) seg_bytes.push_back(lmi_pkg::CH_GT);
      else seg_bytes.push_back(8'($urandom_range(0, 255)));
      send_seg(clr, eot, 1'b0, NO_RESULT);
    end else if (r < 72) begin
      add_text($urandom_range(0, 1) ? ":team#" : ":player#");
      cut = $urandom_range(1, seg_bytes.size() - 1);
      while (seg_bytes.size() > cut) void'(seg_bytes.pop_back());
      if ($urandom_range(0, 1)) seg_bytes.push_back(hot_bytes[3'($urandom_range(0, 7))]);
      send_seg(clr, eot, 1'b0, NO_RESULT);
    end else if (r < 90) begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 1)) seg_bytes.push_back(8'($urandom_range(0, 255)));
        else seg_bytes.push_back(hot_bytes[3'($urandom_range(0, 7))]);
      end
      send_seg(clr, eot, 1'b0, NO_RESULT);
    end else begin
      send_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)), 1'b0, NO_RESULT);
    end
  endtask

  function automatic void report(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    mismatches++;
  endfunction

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result with no request pending, got id %0d", $time, id_value);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      if (added !== want.added) report("added", 32'(want.added), 32'(added));
      if (kind !== want.kind) report("kind", 32'(want.kind), 32'(kind));
      if (id_value !== want.id_value) report("id_value", want.id_value, id_value);
      if (slot !== want.slot) report("slot", 32'(want.slot), 32'(slot));
      if (player_total !== want.player_total)
        report("player_total", 32'(want.player_total), 32'(player_total));
      if (team_total !== want.team_total)
        report("team_total", 32'(want.team_total), 32'(team_total));
    end
  endtask

  // request side, then drain and verdict
  initial begin
    dir_row_t row;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = directed_rows[i];
      seg_bytes.delete();
      for (int k = TEXT_CHARS - 1; k >= 0; k--)
        if (row.text[8*k +: 8] != 8'h00) seg_bytes.push_back(row.text[8*k +: 8]);
      if (seg_bytes.size() == 0)
        send_req(row.code, row.pres, row.clr, row.eot, row.chk, row.want);
      else
        send_seg(row.clr, row.eot, row.chk, row.want);
    end
    while (requests_taken < TOTAL_ITEMS) send_random_seg();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // result side
  initial begin
    int gap;
    wait (!rst);
    forever begin
      if (results_taken == HOLD_OFF_AT)
        gap = HOLD_OFF_LEN;
      else if ((results_taken / 128) % 4 == 1)
        gap = 0;
      else
        gap = $urandom_range(0, 3);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      check_result();
      results_taken++;
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

@@ link_marker_id_extractor.f @@
+incdir+sv
sv/lmi_pkg.sv
sv/lmi_front.sv
sv/lmi_cmd_queue.sv
sv/lmi_back.sv
sv/link_marker_id_extractor.sv
tb/tb_top.sv
